// ===== src/periodic_neighbor_cell_enumerator_assert.svh =====
// Assertion macros for the periodic neighbor cell enumerator.
`ifndef PERIODIC_NEIGHBOR_CELL_ENUMERATOR_ASSERT_SVH
`define PERIODIC_NEIGHBOR_CELL_ENUMERATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define PNCE_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define PNCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PNCE_ASSERT(label, clk, rst_n, prop, msg)
`define PNCE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== src/pnce_pkg.sv =====
package pnce_pkg;

    localparam int CFG_W       = 7;
    localparam int REG_MAX     = 2**CFG_W - 1;
    localparam int CELL_W      = 18;
    localparam int SHIFT_W     = 2;
    localparam int OFS_W       = 2;
    localparam int REG_IDX_W   = 2;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = REG_IDX_W + 2;
    localparam int DIM_MAX_DEF = 64;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(4);

    localparam logic [REG_IDX_W-1:0] REG_CELLS_X = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_CELLS_Y = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_CELLS_Z = 2'd2;

    // neighbor offset slots: -1, 0, +1
    localparam logic [OFS_W-1:0] OFS_NEG = 2'd0;
    localparam logic [OFS_W-1:0] OFS_MID = 2'd1;
    localparam logic [OFS_W-1:0] OFS_POS = 2'd2;

    localparam logic signed [SHIFT_W-1:0] SHIFT_NEG  = 2'sb11;
    localparam logic signed [SHIFT_W-1:0] SHIFT_ZERO = 2'sb00;
    localparam logic signed [SHIFT_W-1:0] SHIFT_POS  = 2'sb01;

    typedef struct packed {
        logic [CFG_W-1:0] cells_x;
        logic [CFG_W-1:0] cells_y;
        logic [CFG_W-1:0] cells_z;
    } t_cfg;

    typedef enum logic [2:0] {
        F_IDLE,
        F_PLANE,
        F_TOTAL,
        F_CHECK,
        F_DIVX,
        F_DIVY,
        F_PUSH
    } t_front_state;

    typedef enum logic {
        B_SCAN,
        B_CENTRE
    } t_back_state;

    // width of an effective dimension
    function automatic int dim_w(input int dim_max);
        int m;
        m = (dim_max < REG_MAX) ? dim_max : REG_MAX;
        return $clog2(m + 1);
    endfunction

    // width holding both a cell index and the grid size
    function automatic int ext_w(input int dim_max);
        int t;
        t = 3 * dim_w(dim_max);
        return (t > CELL_W) ? t : CELL_W;
    endfunction

    // queue entry: error, centre, 3 x/y/z terms, 6 wrap flags
    function automatic int entry_w(input int dim_max);
        return 7 + CELL_W + 18 * dim_w(dim_max);
    endfunction

endpackage

// ===== src/pnce_in_if.sv =====
interface pnce_in_if
    import pnce_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [CELL_W-1:0] centre_cell;

    modport source (output valid, output centre_cell, input ready);
    modport sink (input valid, input centre_cell, output ready);
endinterface

// ===== src/pnce_out_if.sv =====
interface pnce_out_if
    import pnce_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [CELL_W-1:0]         nbr_index;
    logic signed [SHIFT_W-1:0] shift_x;
    logic signed [SHIFT_W-1:0] shift_y;
    logic signed [SHIFT_W-1:0] shift_z;
    logic                      last;
    logic                      index_error;

    modport source (
        output valid, output nbr_index, output shift_x, output shift_y,
        output shift_z, output last, output index_error, input ready
    );
    modport sink (
        input valid, input nbr_index, input shift_x, input shift_y,
        input shift_z, input last, input index_error, output ready
    );
endinterface

// ===== src/pnce_queue.sv =====
module pnce_queue
    import pnce_pkg::*;
#(
    parameter int WIDTH = entry_w(DIM_MAX_DEF),
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr_valid,
    output logic             o_wr_ready,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_rd_valid,
    input  logic             i_rd_ready,
    output logic [WIDTH-1:0] o_rd_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_wr_ready = (r_count != CNT_W'(DEPTH));
    assign o_rd_valid = (r_count != '0);
    assign o_rd_data  = r_mem[r_rptr];
    assign w_push     = i_wr_valid && o_wr_ready;
    assign w_pop      = o_rd_valid && i_rd_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_wptr <= (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (w_pop) begin
                r_rptr <= (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            unique case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wptr] <= i_wr_data;
        end
    end
endmodule

// ===== src/pnce_front.sv =====
module pnce_front
    import pnce_pkg::*;
#(
    parameter int DIM_MAX = DIM_MAX_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_cfg                         i_cfg,
    pnce_in_if.sink                      i_cell_in,
    output logic                         o_q_valid,
    input  logic                         i_q_ready,
    output logic [entry_w(DIM_MAX)-1:0]  o_q_data
);
    localparam int DW = dim_w(DIM_MAX);
    localparam int PW = 2 * DW;
    localparam int TW = 3 * DW;
    localparam int XW = ext_w(DIM_MAX);
    localparam int BW = (DW > 1) ? $clog2(DW) : 1;

    typedef struct packed {
        logic                  err;
        logic [CELL_W-1:0]     centre;
        logic [2:0][TW-1:0]    xt;
        logic [2:0][PW-1:0]    yt;
        logic [2:0][DW-1:0]    zt;
        logic                  x_lo;
        logic                  x_hi;
        logic                  y_lo;
        logic                  y_hi;
        logic                  z_lo;
        logic                  z_hi;
    } t_entry;

    t_front_state      r_state;
    t_front_state      n_state;
    logic [CELL_W-1:0] r_centre;
    logic [DW-1:0]     r_nx;
    logic [DW-1:0]     r_ny;
    logic [DW-1:0]     r_nz;
    logic [PW-1:0]     r_plane;
    logic [TW-1:0]     r_total;
    logic              r_err;
    logic [XW-1:0]     r_rem;
    logic [XW-1:0]     r_trial;
    logic [DW-1:0]     r_q;
    logic [BW-1:0]     r_bit;
    logic [DW-1:0]     r_cx;
    logic [DW-1:0]     r_cy;
    logic [DW-1:0]     r_cz;
    logic [TW-1:0]     r_xbase;
    logic [PW-1:0]     r_ybase;
    logic [PW-1:0]     r_rem1;

    logic              w_out_of_grid;
    logic              w_ge;
    logic [XW-1:0]     w_rem_nx;
    logic [DW-1:0]     w_q_nx;
    logic              w_last_bit;
    t_entry            w_entry;

    function automatic logic [DW-1:0] eff_dim(input logic [CFG_W-1:0] r);
        logic [DW-1:0] d;
        if (r == '0) begin
            d = DW'(1);
        end else if (int'(r) > DIM_MAX) begin
            d = DW'(DIM_MAX);
        end else begin
            d = DW'(r);
        end
        return d;
    endfunction

    // restoring divider step, one quotient bit per cycle
    assign w_out_of_grid = (XW'(r_centre) >= XW'(r_total));
    assign w_ge          = (r_rem >= r_trial);
    assign w_rem_nx      = w_ge ? (r_rem - r_trial) : r_rem;
    assign w_q_nx        = DW'({r_q, w_ge});
    assign w_last_bit    = (r_bit == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE:  if (i_cell_in.valid) n_state = F_PLANE;
            F_PLANE: n_state = F_TOTAL;
            F_TOTAL: n_state = F_CHECK;
            F_CHECK: n_state = w_out_of_grid ? F_PUSH : F_DIVX;
            F_DIVX:  if (w_last_bit) n_state = F_DIVY;
            F_DIVY:  if (w_last_bit) n_state = F_PUSH;
            F_PUSH:  if (i_q_ready) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_comb begin
        i_cell_in.ready = (r_state == F_IDLE);
        o_q_valid       = (r_state == F_PUSH);
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            F_IDLE: begin
                if (i_cell_in.valid) begin
                    r_centre <= i_cell_in.centre_cell;
                    r_nx     <= eff_dim(i_cfg.cells_x);
                    r_ny     <= eff_dim(i_cfg.cells_y);
                    r_nz     <= eff_dim(i_cfg.cells_z);
                end
            end
            F_PLANE: r_plane <= PW'(r_ny) * PW'(r_nz);
            F_TOTAL: r_total <= TW'(r_nx) * TW'(r_plane);
            F_CHECK: begin
                r_err   <= w_out_of_grid;
                r_rem   <= XW'(r_centre);
                r_trial <= XW'(r_plane) << (DW - 1);
                r_q     <= '0;
                r_bit   <= BW'(DW - 1);
            end
            F_DIVX: begin
                r_rem <= w_rem_nx;
                if (w_last_bit) begin
                    r_cx    <= w_q_nx;
                    r_xbase <= TW'(XW'(r_centre) - w_rem_nx);
                    r_rem1  <= PW'(w_rem_nx);
                    r_trial <= XW'(r_nz) << (DW - 1);
                    r_q     <= '0;
                    r_bit   <= BW'(DW - 1);
                end else begin
                    r_q     <= w_q_nx;
                    r_trial <= r_trial >> 1;
                    r_bit   <= r_bit - 1'b1;
                end
            end
            F_DIVY: begin
                r_rem   <= w_rem_nx;
                r_q     <= w_q_nx;
                r_trial <= r_trial >> 1;
                r_bit   <= r_bit - 1'b1;
                if (w_last_bit) begin
                    r_cy    <= w_q_nx;
                    r_cz    <= DW'(w_rem_nx);
                    r_ybase <= r_rem1 - PW'(w_rem_nx);
                end
            end
            F_PUSH: begin
            end
            default: begin
            end
        endcase
    end

    // per-axis terms of the linear index for offsets -1, 0, +1
    always_comb begin
        w_entry.err    = r_err;
        w_entry.centre = r_centre;
        w_entry.x_lo   = (r_cx == '0);
        w_entry.x_hi   = (r_cx == r_nx - DW'(1));
        w_entry.y_lo   = (r_cy == '0);
        w_entry.y_hi   = (r_cy == r_ny - DW'(1));
        w_entry.z_lo   = (r_cz == '0);
        w_entry.z_hi   = (r_cz == r_nz - DW'(1));

        w_entry.xt[OFS_NEG] = w_entry.x_lo ? (r_total - TW'(r_plane))
                                           : (r_xbase - TW'(r_plane));
        w_entry.xt[OFS_MID] = r_xbase;
        w_entry.xt[OFS_POS] = w_entry.x_hi ? '0 : (r_xbase + TW'(r_plane));

        w_entry.yt[OFS_NEG] = w_entry.y_lo ? (r_plane - PW'(r_nz))
                                           : (r_ybase - PW'(r_nz));
        w_entry.yt[OFS_MID] = r_ybase;
        w_entry.yt[OFS_POS] = w_entry.y_hi ? '0 : (r_ybase + PW'(r_nz));

        w_entry.zt[OFS_NEG] = w_entry.z_lo ? (r_nz - DW'(1)) : (r_cz - DW'(1));
        w_entry.zt[OFS_MID] = r_cz;
        w_entry.zt[OFS_POS] = w_entry.z_hi ? '0 : (r_cz + DW'(1));
    end

    assign o_q_data = w_entry;
endmodule

// ===== src/pnce_back.sv =====
module pnce_back
    import pnce_pkg::*;
#(
    parameter int DIM_MAX = DIM_MAX_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    output logic                        o_q_ready,
    input  logic [entry_w(DIM_MAX)-1:0] i_q_data,
    pnce_out_if.source                  o_cell_out
);
    localparam int DW = dim_w(DIM_MAX);
    localparam int PW = 2 * DW;
    localparam int TW = 3 * DW;
    localparam int XW = ext_w(DIM_MAX);

    typedef struct packed {
        logic                  err;
        logic [CELL_W-1:0]     centre;
        logic [2:0][TW-1:0]    xt;
        logic [2:0][PW-1:0]    yt;
        logic [2:0][DW-1:0]    zt;
        logic                  x_lo;
        logic                  x_hi;
        logic                  y_lo;
        logic                  y_hi;
        logic                  z_lo;
        logic                  z_hi;
    } t_entry;

    t_back_state               r_state;
    t_back_state               n_state;
    logic [OFS_W-1:0]          r_dx;
    logic [OFS_W-1:0]          r_dy;
    logic [OFS_W-1:0]          r_dz;
    logic [OFS_W-1:0]          n_dx;
    logic [OFS_W-1:0]          n_dy;
    logic [OFS_W-1:0]          n_dz;
    logic                      r_ov;
    logic [CELL_W-1:0]         r_cell;
    logic signed [SHIFT_W-1:0] r_sx;
    logic signed [SHIFT_W-1:0] r_sy;
    logic signed [SHIFT_W-1:0] r_sz;
    logic                      r_last;
    logic                      r_err;
    logic [CELL_W-1:0]         n_cell;
    logic signed [SHIFT_W-1:0] n_sx;
    logic signed [SHIFT_W-1:0] n_sy;
    logic signed [SHIFT_W-1:0] n_sz;
    logic                      n_last;
    logic                      n_err;

    t_entry                    w_head;
    logic [TW-1:0]             w_cell;
    logic                      w_adv;
    logic                      w_at_end;
    logic                      w_emit;
    logic                      w_step;

    function automatic logic signed [SHIFT_W-1:0] shift_of(
        input logic [OFS_W-1:0] sel,
        input logic             lo,
        input logic             hi
    );
        logic signed [SHIFT_W-1:0] s;
        unique case (sel)
            OFS_NEG: s = lo ? SHIFT_NEG : SHIFT_ZERO;
            OFS_POS: s = hi ? SHIFT_POS : SHIFT_ZERO;
            default: s = SHIFT_ZERO;
        endcase
        return s;
    endfunction

    assign w_head   = i_q_data;
    assign w_cell   = w_head.xt[r_dx] + TW'(w_head.yt[r_dy]) + TW'(w_head.zt[r_dz]);
    assign w_adv    = !r_ov || o_cell_out.ready;
    assign w_at_end = (r_dx == OFS_POS) && (r_dy == OFS_POS) && (r_dz == OFS_POS);

    always_comb begin
        o_q_ready = 1'b0;
        w_emit    = 1'b0;
        w_step    = 1'b0;
        n_cell    = '0;
        n_sx      = SHIFT_ZERO;
        n_sy      = SHIFT_ZERO;
        n_sz      = SHIFT_ZERO;
        n_last    = 1'b0;
        n_err     = 1'b0;
        if (i_q_valid && w_adv) begin
            priority if (w_head.err) begin
                o_q_ready = 1'b1;
                w_emit    = 1'b1;
                n_last    = 1'b1;
                n_err     = 1'b1;
            end else if (r_state == B_CENTRE) begin
                o_q_ready = 1'b1;
                w_emit    = 1'b1;
                n_cell    = w_head.centre;
                n_last    = 1'b1;
            end else begin
                w_step = 1'b1;
                w_emit = (XW'(w_cell) != XW'(w_head.centre));
                n_cell = CELL_W'(w_cell);
                n_sx   = shift_of(r_dx, w_head.x_lo, w_head.x_hi);
                n_sy   = shift_of(r_dy, w_head.y_lo, w_head.y_hi);
                n_sz   = shift_of(r_dz, w_head.z_lo, w_head.z_hi);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_SCAN:   if (w_step && w_at_end) n_state = B_CENTRE;
            B_CENTRE: if (i_q_valid && w_adv) n_state = B_SCAN;
            default:  n_state = B_SCAN;
        endcase
    end

    // z fastest; the centre slot is skipped, it goes out last
    always_comb begin
        n_dx = r_dx;
        n_dy = r_dy;
        n_dz = r_dz;
        priority if (w_at_end) begin
            n_dx = OFS_NEG;
            n_dy = OFS_NEG;
            n_dz = OFS_NEG;
        end else if (r_dz != OFS_POS) begin
            n_dz = r_dz + 2'd1;
        end else begin
            n_dz = OFS_NEG;
            if (r_dy != OFS_POS) begin
                n_dy = r_dy + 2'd1;
            end else begin
                n_dy = OFS_NEG;
                n_dx = r_dx + 2'd1;
            end
        end
        if (n_dx == OFS_MID && n_dy == OFS_MID && n_dz == OFS_MID) begin
            n_dz = OFS_POS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_SCAN;
            r_dx    <= OFS_NEG;
            r_dy    <= OFS_NEG;
            r_dz    <= OFS_NEG;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_step) begin
                r_dx <= n_dx;
                r_dy <= n_dy;
                r_dz <= n_dz;
            end
            if (w_adv) begin
                r_ov <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_emit) begin
            r_cell <= n_cell;
            r_sx   <= n_sx;
            r_sy   <= n_sy;
            r_sz   <= n_sz;
            r_last <= n_last;
            r_err  <= n_err;
        end
    end

    assign o_cell_out.valid       = r_ov;
    assign o_cell_out.nbr_index   = r_cell;
    assign o_cell_out.shift_x     = r_sx;
    assign o_cell_out.shift_y     = r_sy;
    assign o_cell_out.shift_z     = r_sz;
    assign o_cell_out.last        = r_last;
    assign o_cell_out.index_error = r_err;
endmodule

// ===== src/periodic_neighbor_cell_enumerator.sv =====
// Periodic 27-cell neighbor enumerator. Each centre cell index accepted on
// i_cell_in yields its 3x3x3 neighborhood on o_cell_out (x outer, z inner,
// each axis wrapped with its image shift), repeats of the centre dropped,
// the centre itself last with zero shift and last set; an index outside the
// grid gives a single result with index_error and last set. Grid sizes come
// from the three APB registers (0 is taken as 1, above DIM_MAX as DIM_MAX)
// and are sampled when an index is accepted. The back end steps through the
// 26 neighbor slots and then the centre, one step per slot, with at most one
// result per cycle; an out-of-grid index takes a single step, and slots that
// wrap onto the centre use their step without a result. The front end does
// two multiplies and two bit-serial coordinate divides per index, overlapped
// with the back end through a two-entry queue, so a new index can be
// accepted while the back end still works on earlier ones. Output stalls
// stall the back end and reach the front end once the queue is full.
`include "periodic_neighbor_cell_enumerator_assert.svh"

module periodic_neighbor_cell_enumerator
    import pnce_pkg::*;
#(
    parameter int DIM_MAX = DIM_MAX_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    pnce_in_if.sink               i_cell_in,
    pnce_out_if.source            o_cell_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);
    localparam int ENTRY_W = entry_w(DIM_MAX);

    t_cfg                 r_cfg;
    logic                 w_cfg_wr;
    logic [REG_IDX_W-1:0] w_reg_idx;

    logic                 w_push_valid;
    logic                 w_push_ready;
    logic [ENTRY_W-1:0]   w_push_data;
    logic                 w_pop_valid;
    logic                 w_pop_ready;
    logic [ENTRY_W-1:0]   w_pop_data;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cells_x <= CFG_RESET;
            r_cfg.cells_y <= CFG_RESET;
            r_cfg.cells_z <= CFG_RESET;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_CELLS_X: r_cfg.cells_x <= pwdata[CFG_W-1:0];
                REG_CELLS_Y: r_cfg.cells_y <= pwdata[CFG_W-1:0];
                REG_CELLS_Z: r_cfg.cells_z <= pwdata[CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_CELLS_X: prdata = APB_DATA_W'(r_cfg.cells_x);
            REG_CELLS_Y: prdata = APB_DATA_W'(r_cfg.cells_y);
            REG_CELLS_Z: prdata = APB_DATA_W'(r_cfg.cells_z);
            default:     prdata = '0;
        endcase
    end

    pnce_front #(
        .DIM_MAX (DIM_MAX)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_cell_in (i_cell_in),
        .o_q_valid (w_push_valid),
        .i_q_ready (w_push_ready),
        .o_q_data  (w_push_data)
    );

    pnce_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_valid (w_push_valid),
        .o_wr_ready (w_push_ready),
        .i_wr_data  (w_push_data),
        .o_rd_valid (w_pop_valid),
        .i_rd_ready (w_pop_ready),
        .o_rd_data  (w_pop_data)
    );

    pnce_back #(
        .DIM_MAX (DIM_MAX)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (w_pop_valid),
        .o_q_ready  (w_pop_ready),
        .i_q_data   (w_pop_data),
        .o_cell_out (o_cell_out)
    );

    `PNCE_ASSERT(a_err_result_form, i_clk, i_rst_n, o_cell_out.valid && o_cell_out.index_error |-> o_cell_out.last && (o_cell_out.nbr_index == '0), "error result not last or cell nonzero")
    `PNCE_ASSERT(a_last_zero_shift, i_clk, i_rst_n, o_cell_out.valid && o_cell_out.last |-> (o_cell_out.shift_x == SHIFT_ZERO) && (o_cell_out.shift_y == SHIFT_ZERO) && (o_cell_out.shift_z == SHIFT_ZERO), "last result with nonzero shift")
    `PNCE_ASSERT_NEXT(a_front_busy, i_clk, i_rst_n, i_cell_in.valid && i_cell_in.ready, !i_cell_in.ready, "front ready right after a transaction")
    `PNCE_ASSERT_NEXT(a_push_held, i_clk, i_rst_n, w_push_valid && !w_push_ready, w_push_valid, "queue entry dropped while full")
endmodule
